// ===== rtl/core/tslt_pkg.sv =====
package tslt_pkg;

  localparam logic [7:0] ProtoTcp = 8'h06;
  localparam int unsigned FlagFinBit = 0;
  localparam int unsigned FlagSynBit = 1;
  localparam logic [7:0] FlagSynOrAck = 8'h12;

  typedef enum logic {
    FuncCreate = 1'b0,
    FuncUpdate = 1'b1
  } tslt_func_e;

  typedef enum logic [1:0] {
    ModeInline = 2'd0,
    ModeAhead  = 2'd1,
    ModeBehind = 2'd2
  } tslt_mode_e;

  // One flow entry: both directions plus the per-flow flags.
  typedef struct packed {
    logic        created;
    logic        incomplete;
    tslt_mode_e  mode1;
    tslt_mode_e  mode0;
    logic [31:0] exp_seq1;
    logic [31:0] exp_seq0;
  } tslt_row_t;

  localparam int unsigned RowWidth = $bits(tslt_row_t);

  typedef struct packed {
    tslt_func_e  func;
    logic        from_source;
    logic [7:0]  ip_protocol;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] payload_length;
    logic [7:0]  tcp_flag_bits;
  } tslt_item_t;

  typedef struct packed {
    logic loss_now;
    logic flow_incomplete;
    logic ignored;
  } tslt_result_t;

endpackage

// ===== rtl/core/tslt_ram.sv =====
module tslt_ram import tslt_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tslt_update.sv =====
module tslt_update import tslt_pkg::*; (
  input  tslt_row_t    row_i,
  input  tslt_item_t   item_i,
  input  logic         in_range_i,
  output tslt_row_t    row_o,
  output logic         wr_en_o,
  output tslt_result_t result_o
);

  logic        dir1;
  logic        tracked;
  logic [16:0] step;
  logic [31:0] seq_sum;
  logic [31:0] exp_own;
  tslt_mode_e  mode_own;
  tslt_mode_e  mode_new;
  logic        loss;

  assign dir1    = ~item_i.from_source;
  assign tracked = (item_i.ip_protocol == ProtoTcp) && in_range_i;
  assign step    = {1'b0, item_i.payload_length}
                 + {16'd0, item_i.tcp_flag_bits[FlagSynBit]}
                 + {16'd0, item_i.tcp_flag_bits[FlagFinBit]};
  // In line means seq equals the expected value, so seq serves as the base.
  assign seq_sum  = item_i.seq_number + {15'd0, step};
  assign exp_own  = dir1 ? row_i.exp_seq1 : row_i.exp_seq0;
  assign mode_own = dir1 ? row_i.mode1 : row_i.mode0;

  always_comb begin
    if (exp_own > item_i.seq_number) begin
      mode_new = ModeAhead;
      loss     = (mode_own != ModeInline);
    end else if (exp_own < item_i.seq_number) begin
      mode_new = ModeBehind;
      loss     = (mode_own != ModeInline);
    end else begin
      mode_new = ModeInline;
      loss     = (mode_own == ModeBehind);
    end
  end

  always_comb begin
    row_o    = row_i;
    wr_en_o  = 1'b0;
    result_o = '{loss_now: 1'b0, flow_incomplete: 1'b0, ignored: 1'b1};
    if (tracked) begin
      case (item_i.func)
        FuncCreate: begin
          result_o.ignored = 1'b0;
          if (!row_i.created) begin
            wr_en_o          = 1'b1;
            row_o.created    = 1'b1;
            row_o.incomplete = 1'b0;
            row_o.mode0      = ModeInline;
            row_o.mode1      = ModeInline;
            if (dir1) begin
              row_o.exp_seq1 = seq_sum;
              row_o.exp_seq0 = item_i.ack_number;
            end else begin
              row_o.exp_seq0 = seq_sum;
              row_o.exp_seq1 = item_i.ack_number;
            end
          end
          result_o.flow_incomplete = row_o.incomplete;
        end
        FuncUpdate: begin
          if (row_i.created) begin
            wr_en_o          = 1'b1;
            result_o.ignored = 1'b0;
            if (((item_i.tcp_flag_bits & FlagSynOrAck) != 8'd0) && (exp_own == 32'd0)) begin
              if (dir1) begin
                row_o.exp_seq1 = seq_sum;
              end else begin
                row_o.exp_seq0 = seq_sum;
              end
            end else begin
              if (dir1) begin
                row_o.mode1 = mode_new;
              end else begin
                row_o.mode0 = mode_new;
                result_o.loss_now = loss;
                if (loss) begin
                  row_o.incomplete = 1'b1;
                end
              end
              if (mode_new == ModeInline) begin
                if (dir1) begin
                  row_o.exp_seq1 = seq_sum;
                end else begin
                  row_o.exp_seq0 = seq_sum;
                end
              end else if (mode_new == ModeBehind) begin
                if (dir1) begin
                  row_o.exp_seq1 = item_i.seq_number;
                end else begin
                  row_o.exp_seq0 = item_i.seq_number;
                end
              end
            end
            result_o.flow_incomplete = row_o.incomplete;
          end
        end
        default: begin
          wr_en_o = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tcp_sequence_loss_tracker.sv =====
// Per-flow TCP sequence tracker that flags packet loss on the source direction.
// The input channel takes one packet header word per accepted handshake
// (in_valid_i high, in_stall_o low). The output channel returns one result word
// per packet, in order, with the loss flag, the flow's sticky incomplete flag
// and an ignored flag.
// Each flow occupies one row of a single flow table RAM with a registered read.
// A word accepted at one clock edge reads its row at that edge, is evaluated from
// the registered row and its registered header word, and its result is then
// registered in the output register. A new word can be taken every cycle while
// in_stall_o is low; a row written by the previous word is forwarded to the next one.
// After reset the flow table is cleared one row per cycle, and in_stall_o stays
// high during that pass.
// When the receiver stalls, the result register holds its word, the word under
// evaluation waits behind it and in_stall_o rises, so nothing is lost.
module tcp_sequence_loss_tracker import tslt_pkg::*; #(
  parameter int unsigned FLOW_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  flow_index_i,
  input  logic        from_source_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  tcp_flag_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        loss_now_o,
  output logic        flow_incomplete_o,
  output logic        ignored_o
);

  localparam int unsigned FlowAw = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;

  logic              clr_active_q, clr_active_d;
  logic [FlowAw-1:0] clr_cnt_q, clr_cnt_d;
  logic              s1_valid_q, s1_valid_d;
  tslt_item_t        s1_item_q;
  logic [FlowAw-1:0] s1_addr_q;
  logic              s1_in_range_q;
  logic              out_valid_q, out_valid_d;
  tslt_result_t      out_res_q;
  logic              byp_hit_q;
  tslt_row_t         byp_row_q;

  logic              accept;
  logic              out_ready;
  logic              advance;
  logic [FlowAw-1:0] in_addr;
  logic              in_range;
  logic              ram_we;
  logic [FlowAw-1:0] ram_waddr;
  tslt_row_t         ram_wdata;
  logic [RowWidth-1:0] ram_rdata;
  tslt_row_t         cur_row;
  tslt_row_t         new_row;
  logic              upd_we;
  tslt_result_t      upd_res;

  assign in_addr   = FlowAw'(flow_index_i);
  assign in_range  = ({24'd0, flow_index_i} < 32'(FLOW_COUNT));
  assign out_ready = ~out_valid_q | ~out_stall_i;
  assign advance   = s1_valid_q & out_ready;
  assign in_stall_o = clr_active_q | (s1_valid_q & ~out_ready);
  assign accept    = in_valid_i & ~in_stall_o;

  assign ram_we    = clr_active_q | (advance & upd_we);
  assign ram_waddr = clr_active_q ? clr_cnt_q : s1_addr_q;
  assign ram_wdata = clr_active_q ? tslt_row_t'('0) : new_row;

  tslt_ram #(
    .Width(RowWidth),
    .Depth(FLOW_COUNT)
  ) u_flow_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  assign cur_row = byp_hit_q ? byp_row_q : tslt_row_t'(ram_rdata);

  tslt_update u_update (
    .row_i     (cur_row),
    .item_i    (s1_item_q),
    .in_range_i(s1_in_range_q),
    .row_o     (new_row),
    .wr_en_o   (upd_we),
    .result_o  (upd_res)
  );

  always_comb begin
    clr_active_d = clr_active_q;
    clr_cnt_d    = clr_cnt_q;
    if (clr_active_q) begin
      if (clr_cnt_q == FlowAw'(FLOW_COUNT - 1)) begin
        clr_active_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + FlowAw'(1);
      end
    end
    s1_valid_d = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_cnt_q    <= clr_cnt_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.func           <= tslt_func_e'(func_i);
      s1_item_q.from_source    <= from_source_i;
      s1_item_q.ip_protocol    <= ip_protocol_i;
      s1_item_q.seq_number     <= seq_number_i;
      s1_item_q.ack_number     <= ack_number_i;
      s1_item_q.payload_length <= payload_length_i;
      s1_item_q.tcp_flag_bits  <= tcp_flag_bits_i;
      s1_addr_q                <= in_addr;
      s1_in_range_q            <= in_range;
      byp_hit_q                <= ram_we && (ram_waddr == in_addr);
      byp_row_q                <= ram_wdata;
    end
    if (advance) begin
      out_res_q <= upd_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign loss_now_o        = out_res_q.loss_now;
  assign flow_incomplete_o = out_res_q.flow_incomplete;
  assign ignored_o         = out_res_q.ignored;

  a_loss_sets_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && loss_now_o |-> flow_incomplete_o && !ignored_o)
    else $error("Loss reported without the incomplete flag.");

  a_ignored_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ignored_o |-> !loss_now_o && !flow_incomplete_o)
    else $error("Ignored word carries a loss or incomplete flag.");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> in_stall_o)
    else $error("Input taken during the table clearing pass.");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_addr_q))
    else $error("Pending word lost while the output is stalled.");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_res_q))
    else $error("Stalled result word changed.");

endmodule

// ===== tb/tb_tcp_sequence_loss_tracker.sv =====
module tb_tcp_sequence_loss_tracker;
  import tslt_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldOffCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [7:0]  flow_index_i = '0;
  logic        from_source_i = 1'b0;
  logic [7:0]  ip_protocol_i = '0;
  logic [31:0] seq_number_i = '0;
  logic [31:0] ack_number_i = '0;
  logic [15:0] payload_length_i = '0;
  logic [7:0]  tcp_flag_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        loss_now_o;
  logic        flow_incomplete_o;
  logic        ignored_o;

  tcp_sequence_loss_tracker dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .func_i,
    .flow_index_i,
    .from_source_i,
    .ip_protocol_i,
    .seq_number_i,
    .ack_number_i,
    .payload_length_i,
    .tcp_flag_bits_i,
    .out_valid_o,
    .out_stall_i,
    .loss_now_o,
    .flow_incomplete_o,
    .ignored_o
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the flow table.
  logic [31:0] flow_next_seq [512];
  tslt_mode_e  flow_mode [512];
  logic        flow_lossy [256];
  logic        flow_open [256];

  tslt_result_t verdict_q [$];
  tslt_result_t last_verdict;
  tslt_result_t due;
  logic [7:0]   live_flows [8];
  int unsigned  errors = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  hold_left = 0;
  logic         hold_req = 1'b0;
  logic         sender_quiet = 1'b0;
  logic         sink_quiet = 1'b0;

  function automatic tslt_result_t judge_packet(input tslt_item_t h, input logic [7:0] flow);
    tslt_result_t r;
    logic [8:0]   slot;
    logic [31:0]  cur;
    logic [31:0]  grown;
    tslt_mode_e   old_mode;
    tslt_mode_e   next_mode;
    logic         lost;
    r = '{loss_now: 1'b0, flow_incomplete: 1'b0, ignored: 1'b1};
    if (h.ip_protocol != ProtoTcp) return r;
    slot = {flow, ~h.from_source};
    grown = h.seq_number + {16'd0, h.payload_length}
            + {31'd0, h.tcp_flag_bits[FlagSynBit]}
            + {31'd0, h.tcp_flag_bits[FlagFinBit]};
    lost = 1'b0;
    if (h.func == FuncCreate) begin
      if (!flow_open[flow]) begin
        flow_next_seq[slot] = grown;
        flow_next_seq[slot ^ 9'd1] = h.ack_number;
        flow_mode[{flow, 1'b0}] = ModeInline;
        flow_mode[{flow, 1'b1}] = ModeInline;
        flow_lossy[flow] = 1'b0;
        flow_open[flow] = 1'b1;
      end
    end else begin
      if (!flow_open[flow]) return r;
      if ((h.tcp_flag_bits & FlagSynOrAck) != '0 && flow_next_seq[slot] == '0) begin
        flow_next_seq[slot] = grown;
      end else begin
        cur = flow_next_seq[slot];
        old_mode = flow_mode[slot];
        if (cur > h.seq_number) begin
          lost = (old_mode != ModeInline);
          next_mode = ModeAhead;
        end else if (cur < h.seq_number) begin
          lost = (old_mode != ModeInline);
          next_mode = ModeBehind;
        end else begin
          lost = (old_mode == ModeBehind);
          next_mode = ModeInline;
        end
        flow_mode[slot] = next_mode;
        if (!h.from_source) lost = 1'b0;
        if (lost) flow_lossy[flow] = 1'b1;
        if (next_mode == ModeInline) flow_next_seq[slot] = grown;
        else if (next_mode == ModeBehind) flow_next_seq[slot] = h.seq_number;
      end
    end
    r.loss_now = lost;
    r.flow_incomplete = flow_lossy[flow];
    r.ignored = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] pick_length();
    if ($urandom_range(99) < 80) return 16'($urandom_range(1500));
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_pkt(input tslt_func_e fn, input logic [7:0] flow, input logic src,
                          input logic [7:0] proto, input logic [31:0] sq,
                          input logic [31:0] ak, input logic [15:0] len,
                          input logic [7:0] flags);
    tslt_item_t h;
    h = '{func: fn, from_source: src, ip_protocol: proto, seq_number: sq,
          ack_number: ak, payload_length: len, tcp_flag_bits: flags};
    while (!sender_quiet && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    func_i <= h.func;
    flow_index_i <= flow;
    from_source_i <= src;
    ip_protocol_i <= proto;
    seq_number_i <= sq;
    ack_number_i <= ak;
    payload_length_i <= len;
    tcp_flag_bits_i <= flags;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_verdict = judge_packet(h, flow);
    verdict_q.push_back(last_verdict);
  endtask

  task automatic wait_for_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic expv, input logic got);
    if (got !== expv) begin
      errors++;
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, expv, got);
    end
  endtask

  // Receiver side: random stalls, a counted hold-off on request, quiet stretches.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (sink_quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < 21);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual loss=%0b inc=%0b ign=%0b",
                 $time, loss_now_o, flow_incomplete_o, ignored_o);
      end else begin
        due = verdict_q.pop_front();
        check_field("loss_now", due.loss_now, loss_now_o);
        check_field("flow_incomplete", due.flow_incomplete, flow_incomplete_o);
        check_field("ignored", due.ignored, ignored_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 verdict_q.size());
        $display("tcp_sequence_loss_tracker regression: fail");
        $finish;
      end
    end
  end

  task automatic test_untracked_packets();
    send_pkt(FuncCreate, 8'd10, 1'b1, 8'h07, 32'd1, 32'd2, 16'd3, 8'h00);
    send_pkt(FuncUpdate, 8'd10, 1'b1, 8'h00, 32'd1, 32'd2, 16'd3, 8'hFF);
    send_pkt(FuncCreate, 8'd11, 1'b0, 8'hFF, '1, '1, '1, 8'hFF);
    send_pkt(FuncUpdate, 8'd200, 1'b1, ProtoTcp, 32'd5, 32'd6, 16'd7, 8'h12);
    wait_for_verdicts();
  endtask

  task automatic test_flow_creation();
    send_pkt(FuncCreate, 8'd0, 1'b1, ProtoTcp, 32'd0, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncCreate, 8'd255, 1'b0, ProtoTcp, '1, '1, 16'hFFFF, 8'h03);
    send_pkt(FuncUpdate, 8'd255, 1'b0, ProtoTcp, 32'h0000_FFFF, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncCreate, 8'd255, 1'b1, ProtoTcp, 32'd9, 32'd9, 16'd9, 8'h02);
    wait_for_verdicts();
  endtask

  task automatic test_sequence_tracking();
    send_pkt(FuncCreate, 8'd3, 1'b1, ProtoTcp, 32'd1000, 32'd5000, 16'd100, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1100, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1300, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1300, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1200, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1000, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1300, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1400, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b1, ProtoTcp, 32'd1500, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b0, ProtoTcp, 32'd4000, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd3, 1'b0, ProtoTcp, 32'd6000, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncCreate, 8'd3, 1'b0, ProtoTcp, 32'd1, 32'd1, 16'd1, 8'h00);
    send_pkt(FuncCreate, 8'd4, 1'b1, ProtoTcp, 32'd50, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd4, 1'b0, ProtoTcp, 32'd77, 32'd0, 16'd3, 8'h10);
    send_pkt(FuncUpdate, 8'd4, 1'b0, ProtoTcp, 32'd80, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncCreate, 8'd5, 1'b1, ProtoTcp, 32'd50, 32'd0, 16'd0, 8'h00);
    send_pkt(FuncUpdate, 8'd5, 1'b0, ProtoTcp, 32'd0, 32'd0, 16'd0, 8'h00);
    wait_for_verdicts();
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned tracked;
    int unsigned roll;
    int unsigned pick;
    logic [7:0]  f;
    logic        src;
    logic [31:0] base;
    logic [31:0] sq;
    tracked = 0;
    for (int i = 0; i < 8; i++) begin
      live_flows[i] = 8'($urandom_range(255));
      send_pkt(FuncCreate, live_flows[i], 1'($urandom_range(1)), ProtoTcp, $urandom,
               $urandom, pick_length(), 8'($urandom_range(255)));
    end
    while (tracked < target) begin
      roll = $urandom_range(99);
      src = 1'($urandom_range(1));
      if (roll < 8) begin
        send_pkt($urandom_range(1) ? FuncUpdate : FuncCreate, 8'($urandom_range(255)), src,
                 8'($urandom_range(255)), $urandom, $urandom, 16'($urandom_range(65535)),
                 8'($urandom_range(255)));
      end else if (roll < 14) begin
        pick = $urandom_range(7);
        live_flows[pick] = 8'($urandom_range(255));
        send_pkt(FuncCreate, live_flows[pick], src, ProtoTcp, $urandom,
                 ($urandom_range(3) == 0) ? 32'd0 : $urandom, pick_length(),
                 8'($urandom_range(255)));
      end else begin
        f = live_flows[$urandom_range(7)];
        base = flow_next_seq[{f, ~src}];
        roll = $urandom_range(99);
        if (roll < 60) sq = base;
        else if (roll < 75) sq = base - $urandom_range(1, 3000);
        else if (roll < 90) sq = base + $urandom_range(1, 3000);
        else sq = $urandom;
        send_pkt(FuncUpdate, f, src, ProtoTcp, sq, $urandom, pick_length(),
                 8'($urandom_range(255)));
      end
      if (!last_verdict.ignored) tracked++;
    end
  endtask

  task automatic test_receiver_holdoff();
    sender_quiet = 1'b1;
    hold_req = 1'b1;
    random_traffic(12);
    sender_quiet = 1'b0;
    wait_for_verdicts();
  endtask

  task automatic test_back_to_back();
    sender_quiet = 1'b1;
    sink_quiet = 1'b1;
    random_traffic(60);
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
    wait_for_verdicts();
  endtask

  task automatic test_random_traffic();
    random_traffic(250);
    wait_for_verdicts();
  endtask

  initial begin
    for (int i = 0; i < 512; i++) begin
      flow_next_seq[i] = '0;
      flow_mode[i] = ModeInline;
    end
    for (int i = 0; i < 256; i++) begin
      flow_lossy[i] = 1'b0;
      flow_open[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_untracked_packets();
    test_flow_creation();
    test_sequence_tracking();
    test_receiver_holdoff();
    test_back_to_back();
    test_random_traffic();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tcp_sequence_loss_tracker regression: pass");
    end else begin
      $display("tcp_sequence_loss_tracker regression: fail");
    end
    $finish;
  end

endmodule

// ===== tcp_sequence_loss_tracker.f =====
rtl/core/tslt_pkg.sv
rtl/core/tslt_ram.sv
rtl/core/tslt_update.sv
rtl/core/tcp_sequence_loss_tracker.sv
tb/tb_tcp_sequence_loss_tracker.sv
